// File: design/tua_pkg.sv
// tua_pkg: shared types and constants of the texture unit allocator
// used by tua_unit_cell, tua_order_cell and texture_unit_fifo_allocator
`default_nettype none

package tua_pkg;

  localparam int NUM_UNITS_DEF   = 16;
  localparam int HANDLE_BITS_DEF = 32;

  // widths of the fixed port fields
  localparam int TEX_HANDLE_W = 32;
  localparam int UNIT_INDEX_W = 4;

  // request command codes
  localparam logic CMD_BIND   = 1'b0;
  localparam logic CMD_UNBIND = 1'b1;

  // per-unit controls for one update
  typedef struct packed {
    logic load;     // store new handle, mark busy
    logic free;     // clear busy
  } unit_ctl_t;

  // order list controls for one update
  typedef struct packed {
    logic to_back;
    logic to_front;
  } order_ctl_t;

endpackage

`default_nettype wire

// File: design/tua_unit_cell.sv
// tua_unit_cell: one texture unit, holds handle and busy flag and compares
// the incoming handle; depends on tua_pkg
`default_nettype none

module tua_unit_cell #(
  parameter int HANDLE_BITS = tua_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tua_pkg::unit_ctl_t     ctl,
  input  wire logic [HANDLE_BITS-1:0] cmp_handle,
  input  wire logic [HANDLE_BITS-1:0] wr_handle,
  output logic                        match,
  output logic [HANDLE_BITS-1:0]      handle,
  output logic                        busy
);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.load) begin
      busy <= 1'b1;
    end else if (ctl.free) begin
      busy <= 1'b0;
    end
  end

  // a freed unit keeps its handle but never matches
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      handle <= wr_handle;
    end
  end

  assign match = busy && (handle == cmp_handle);

endmodule

`default_nettype wire

// File: design/tua_order_cell.sv
// tua_order_cell: one position of the replacement order list, shifts toward
// its neighbors when a unit moves to the back or front; depends on tua_pkg
`default_nettype none

module tua_order_cell #(
  parameter int UIDX_W = 4,
  parameter int POS    = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tua_pkg::order_ctl_t ctl,
  input  wire logic [UIDX_W-1:0]   unit,
  input  wire logic                seen_in,
  input  wire logic [UIDX_W-1:0]   left_entry,
  input  wire logic [UIDX_W-1:0]   right_entry,
  output logic [UIDX_W-1:0]        entry,
  output logic                     seen_out
);

  logic hit;

  assign hit      = (entry == unit);
  // true at and after the position that holds the unit
  assign seen_out = seen_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= UIDX_W'(POS);
    end else if (ctl.to_back && seen_out) begin
      entry <= right_entry;
    end else if (ctl.to_front && !seen_in) begin
      entry <= left_entry;
    end
  end

endmodule

`default_nettype wire

// File: design/texture_unit_fifo_allocator.sv
// texture_unit_fifo_allocator: top level, lookup, update sequencer and result
// register; depends on tua_pkg, tua_unit_cell and tua_order_cell
//
// Usage: a request (command, tex_handle) enters on in_valid/in_ready. Bind
// returns the unit that holds the handle, or takes the unit at the front of
// the order list (evicting its handle if busy) and moves it to the back.
// Unbind of a held handle frees the unit and moves it to the front.
// One result per request leaves on out_valid/out_ready.
// Timing: the handle is compared against all units in the accept cycle and
// the match is registered; the update step (S_UPD) then applies the update
// and loads the result register, which raises out_valid.
// The two-step lookup/update sequencer holds one request at a time, so
// in_ready is high only while no request is in flight.
// The order list update ripples through a row of order cells, one per unit.
// Stall: if the result register is still full, the update waits in place
// until out_ready frees it; a waiting result does not block the next
// request once its update has been applied.
// Reset: all units idle, order list 0..NUM_UNITS-1, no active unit,
// no result pending.
`default_nettype none

module texture_unit_fifo_allocator #(
  parameter int NUM_UNITS   = tua_pkg::NUM_UNITS_DEF,
  parameter int HANDLE_BITS = tua_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              command,
  input  wire logic [tua_pkg::TEX_HANDLE_W-1:0]  tex_handle,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tua_pkg::UNIT_INDEX_W-1:0]       unit_index,
  output logic                                   found,
  output logic                                   evicted,
  output logic [tua_pkg::TEX_HANDLE_W-1:0]       evicted_handle,
  output logic                                   active_changed
);

  localparam int UIDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t state;

  logic                   req_cmd;
  logic [HANDLE_BITS-1:0] req_handle;
  logic                   req_hit;
  logic [UIDX_W-1:0]      req_unit;
  logic                   active_valid;
  logic [UIDX_W-1:0]      active_index;

  logic [HANDLE_BITS-1:0] in_handle;
  logic [NUM_UNITS-1:0]   match_vec;
  logic [NUM_UNITS-1:0]   busy_vec;
  logic [HANDLE_BITS-1:0] handles [NUM_UNITS];
  logic [UIDX_W-1:0]      entries [NUM_UNITS];
  logic [NUM_UNITS:0]     seen;
  logic                   lookup_hit;
  logic [UIDX_W-1:0]      lookup_unit;

  logic                   in_fire;
  logic                   upd_go;
  logic                   is_bind;
  logic [UIDX_W-1:0]      unit_sel;
  logic                   evict_now;
  logic                   changed_now;
  logic [HANDLE_BITS-1:0] old_handle;
  logic [tua_pkg::UNIT_INDEX_W-1:0] unit_ext;
  logic [tua_pkg::TEX_HANDLE_W-1:0] old_ext;
  tua_pkg::order_ctl_t    order_ctl;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign upd_go   = (state == S_UPD) && (!out_valid || out_ready);

  // handle width conversions
  if (HANDLE_BITS >= tua_pkg::TEX_HANDLE_W) begin : g_wide
    assign in_handle = {{(HANDLE_BITS - tua_pkg::TEX_HANDLE_W){1'b0}}, tex_handle};
    assign old_ext   = old_handle[tua_pkg::TEX_HANDLE_W-1:0];
  end else begin : g_narrow
    assign in_handle = tex_handle[HANDLE_BITS-1:0];
    assign old_ext   = {{(tua_pkg::TEX_HANDLE_W - HANDLE_BITS){1'b0}}, old_handle};
  end

  if (UIDX_W >= tua_pkg::UNIT_INDEX_W) begin : g_idx_wide
    assign unit_ext = unit_sel[tua_pkg::UNIT_INDEX_W-1:0];
  end else begin : g_idx_narrow
    assign unit_ext = {{(tua_pkg::UNIT_INDEX_W - UIDX_W){1'b0}}, unit_sel};
  end

  // lowest matching unit
  always_comb begin
    lookup_hit  = 1'b0;
    lookup_unit = '0;
    for (int i = NUM_UNITS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        lookup_hit  = 1'b1;
        lookup_unit = UIDX_W'(i);
      end
    end
  end

  // update decisions, from the registered lookup
  always_comb begin
    is_bind     = (req_cmd == tua_pkg::CMD_BIND);
    unit_sel    = '0;
    evict_now   = 1'b0;
    changed_now = 1'b0;
    if (is_bind) begin
      unit_sel    = req_hit ? req_unit : entries[0];
      evict_now   = !req_hit && busy_vec[unit_sel];
      changed_now = !active_valid || (active_index != unit_sel);
    end else if (req_hit) begin
      unit_sel = req_unit;
    end
    old_handle = evict_now ? handles[unit_sel] : '0;
    order_ctl.to_back  = upd_go && is_bind && !req_hit;
    order_ctl.to_front = upd_go && !is_bind && req_hit;
  end

  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_unit
    tua_pkg::unit_ctl_t ctl;
    assign ctl.load = order_ctl.to_back && (unit_sel == UIDX_W'(u));
    assign ctl.free = order_ctl.to_front && (unit_sel == UIDX_W'(u));
    tua_unit_cell #(
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmp_handle (in_handle),
      .wr_handle  (req_handle),
      .match      (match_vec[u]),
      .handle     (handles[u]),
      .busy       (busy_vec[u])
    );
  end

  // order list: ends take the moving unit, inner cells take a neighbor
  assign seen[0] = 1'b0;
  for (genvar p = 0; p < NUM_UNITS; p++) begin : g_order
    logic [UIDX_W-1:0] left_entry;
    logic [UIDX_W-1:0] right_entry;
    if (p == 0) begin : g_first
      assign left_entry = unit_sel;
    end else begin : g_left
      assign left_entry = entries[p-1];
    end
    if (p == NUM_UNITS - 1) begin : g_last
      assign right_entry = unit_sel;
    end else begin : g_right
      assign right_entry = entries[p+1];
    end
    tua_order_cell #(
      .UIDX_W (UIDX_W),
      .POS    (p)
    ) u_order (
      .clk         (clk),
      .rst         (rst),
      .ctl         (order_ctl),
      .unit        (unit_sel),
      .seen_in     (seen[p]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[p]),
      .seen_out    (seen[p+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      active_valid <= 1'b0;
      active_index <= '0;
    end else begin
      if (out_valid && out_ready && !upd_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            if (is_bind) begin
              active_valid <= 1'b1;
              active_index <= unit_sel;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_cmd    <= command;
      req_handle <= in_handle;
      req_hit    <= lookup_hit;
      req_unit   <= lookup_unit;
    end
    if (upd_go) begin
      unit_index     <= unit_ext;
      found          <= req_hit;
      evicted        <= evict_now;
      evicted_handle <= old_ext;
      active_changed <= changed_now;
    end
  end

`ifndef SYNTHESIS
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("handle held by more than one busy unit");

  a_evict_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !found)
    else $error("eviction reported on a found handle");

  a_upd_result: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> out_valid && state == S_IDLE)
    else $error("update did not produce a result");

  a_bind_active: assert property (@(posedge clk) disable iff (rst)
    upd_go && is_bind |=> active_valid && active_index == $past(unit_sel))
    else $error("active unit not set by bind");
`endif

endmodule

`default_nettype wire
